FILE: rtl/expiring_quarantine_table_assert.svh
// assertion macros for the quarantine table checker
`ifndef EXPIRING_QUARANTINE_TABLE_ASSERT_SVH
`define EXPIRING_QUARANTINE_TABLE_ASSERT_SVH

// same-cycle implication
`define EQT_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("eqt: %s failed", "label");

// next-cycle implication
`define EQT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("eqt: %s failed", "label");

`endif

FILE: rtl/eqt_pkg.sv
package eqt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int KIND_BITS_DEF     = 4;

    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_CHECK    = 2'd1;
    localparam logic [1:0] CMD_SNAPSHOT = 2'd2;

    localparam logic [31:0] HOLD_RESET = 32'd60000;
    localparam logic [0:0]  REG_HOLD   = 1'b0;

    typedef struct packed {
        logic ld;
        logic rd;
        logic wr_hit;
        logic wr_fill;
        logic clr;
        logic emit_chk;
        logic push;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic live;
        logic held;
    } t_dp_stat;

endpackage

FILE: rtl/expiring_quarantine_table.sv
// expiring quarantine table
// input word: start with command, kind, key, progress and now_ms, taken when busy is low.
// insert rewrites the first matching slot or the round-robin slot; it gives no result.
// check gives one result word with is_held as its answer and last set on it.
// snapshot gives one word per live, unexpired slot in slot order, the final one
// marked by last, or one empty marker when no slot is live.
// results appear for one cycle under o_result_valid; the receiver cannot stall,
// so every word must be taken in its cycle.
// the slot scan reads one slot at a time, a registered memory read (S_RD) then a
// compare (S_CMP); a snapshot visits every slot and then a flush state before its
// final word, a check or insert ends at the first match or at the last slot.
// busy stays high throughout the scan.
// the hold_duration_ms register sits at address 0 of the apb port, pready is
// always high; write it only while busy is low.
// reset clears every slot valid bit, the fill pointer and sets the hold to 60000.
module expiring_quarantine_table #(
    parameter int TABLE_ENTRIES = eqt_pkg::TABLE_ENTRIES_DEF,
    parameter int KIND_BITS     = eqt_pkg::KIND_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_command,
    input  logic [KIND_BITS-1:0] i_kind,
    input  logic [63:0]          i_key,
    input  logic [63:0]          i_progress,
    input  logic [63:0]          i_now_ms,
    output logic                 o_result_valid,
    output logic                 o_is_held,
    output logic                 o_entry_valid,
    output logic [KIND_BITS-1:0] o_entry_kind,
    output logic [63:0]          o_entry_key,
    output logic [63:0]          o_entry_progress,
    output logic [63:0]          o_entry_failed_at,
    output logic [63:0]          o_entry_expires_at,
    output logic                 o_last,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import eqt_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [31:0]   r_hold;
    t_dp_cmd       dp_cmd;
    t_dp_stat      dp_stat;
    logic [IW-1:0] scan_idx;
    logic          hold_sel;

    assign pready   = 1'b1;
    assign hold_sel = (paddr[2] == REG_HOLD) && (paddr[1:0] == 2'b00);
    assign prdata   = hold_sel ? r_hold : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= HOLD_RESET;
        end else if (psel && penable && pwrite && hold_sel) begin
            r_hold <= pwdata;
        end
    end

    eqt_ctrl #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .IW(IW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_command(i_command),
        .i_kind_nz(i_kind != '0),
        .i_stat   (dp_stat),
        .o_cmd    (dp_cmd),
        .o_idx    (scan_idx),
        .busy     (busy)
    );

    eqt_datapath #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .KIND_BITS(KIND_BITS),
        .IW(IW)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .i_idx             (scan_idx),
        .i_hold            (r_hold),
        .i_kind            (i_kind),
        .i_key             (i_key),
        .i_progress        (i_progress),
        .i_now_ms          (i_now_ms),
        .o_stat            (dp_stat),
        .o_result_valid    (o_result_valid),
        .o_is_held         (o_is_held),
        .o_entry_valid     (o_entry_valid),
        .o_entry_kind      (o_entry_kind),
        .o_entry_key       (o_entry_key),
        .o_entry_progress  (o_entry_progress),
        .o_entry_failed_at (o_entry_failed_at),
        .o_entry_expires_at(o_entry_expires_at),
        .o_last            (o_last)
    );

endmodule

FILE: rtl/eqt_ctrl.sv
module eqt_ctrl #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IW            = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [1:0]       i_command,
    input  logic             i_kind_nz,
    input  eqt_pkg::t_dp_stat i_stat,
    output eqt_pkg::t_dp_cmd o_cmd,
    output logic [IW-1:0]    o_idx,
    output logic             busy
);
    import eqt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RD, S_CMP, S_FLUSH} t_state;

    t_state        r_state;
    logic [1:0]    r_op;
    logic [IW-1:0] r_idx;
    logic          take;
    logic          last_idx;

    assign busy     = (r_state != S_IDLE);
    assign o_idx    = r_idx;
    assign last_idx = (r_idx == IW'(TABLE_ENTRIES - 1));
    assign take     = (r_state == S_IDLE) && start &&
                      ((i_command == CMD_CHECK) || (i_command == CMD_SNAPSHOT) ||
                       ((i_command == CMD_INSERT) && i_kind_nz));

    always_comb begin
        o_cmd     = '0;
        o_cmd.ld  = take;
        o_cmd.rd  = (r_state == S_RD);
        o_cmd.fin = (r_state == S_FLUSH);
        if (r_state == S_CMP) begin
            unique case (r_op)
                CMD_INSERT: begin
                    o_cmd.wr_hit  = i_stat.hit;
                    o_cmd.wr_fill = !i_stat.hit && last_idx;
                end
                CMD_CHECK: begin
                    o_cmd.emit_chk = i_stat.hit || last_idx;
                    o_cmd.clr      = i_stat.hit && !i_stat.held;
                end
                default: o_cmd.push = i_stat.live;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= CMD_INSERT;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (take) begin
                        r_op    <= i_command;
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_CMP;
                S_CMP: begin
                    if (r_op == CMD_SNAPSHOT) begin
                        if (last_idx) r_state <= S_FLUSH;
                        else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end
                    end else if (o_cmd.wr_hit || o_cmd.wr_fill || o_cmd.emit_chk) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/eqt_datapath.sv
module eqt_datapath #(
    parameter int TABLE_ENTRIES = 16,
    parameter int KIND_BITS     = 4,
    parameter int IW            = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  eqt_pkg::t_dp_cmd     i_cmd,
    input  logic [IW-1:0]        i_idx,
    input  logic [31:0]          i_hold,
    input  logic [KIND_BITS-1:0] i_kind,
    input  logic [63:0]          i_key,
    input  logic [63:0]          i_progress,
    input  logic [63:0]          i_now_ms,
    output eqt_pkg::t_dp_stat    o_stat,
    output logic                 o_result_valid,
    output logic                 o_is_held,
    output logic                 o_entry_valid,
    output logic [KIND_BITS-1:0] o_entry_kind,
    output logic [63:0]          o_entry_key,
    output logic [63:0]          o_entry_progress,
    output logic [63:0]          o_entry_failed_at,
    output logic [63:0]          o_entry_expires_at,
    output logic                 o_last
);
    import eqt_pkg::*;

    logic [KIND_BITS-1:0] mem_kind [TABLE_ENTRIES];
    logic [63:0]          mem_key  [TABLE_ENTRIES];
    logic [63:0]          mem_prog [TABLE_ENTRIES];
    logic [63:0]          mem_fail [TABLE_ENTRIES];
    logic [63:0]          mem_exp  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_slot_valid;
    logic [IW-1:0]        r_fp;

    logic [KIND_BITS-1:0] r_kind, r_rd_kind, r_pd_kind;
    logic [63:0] r_key, r_prog, r_now, r_exp;
    logic [63:0] r_rd_key, r_rd_prog, r_rd_fail, r_rd_exp;
    logic [63:0] r_pd_key, r_pd_prog, r_pd_fail, r_pd_exp;
    logic        r_rd_valid, r_have;
    logic [IW-1:0] wa;

    assign wa          = i_cmd.wr_hit ? i_idx : r_fp;
    assign o_stat.hit  = r_rd_valid && (r_rd_kind == r_kind) && (r_rd_key == r_key);
    assign o_stat.live = r_rd_valid && (r_now < r_rd_exp);
    assign o_stat.held = o_stat.live && (r_rd_prog == r_prog);

    // latched word and table storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_kind <= i_kind;
            r_key  <= i_key;
            r_prog <= i_progress;
            r_now  <= i_now_ms;
            r_exp  <= i_now_ms + {32'd0, i_hold};
        end
        if (i_cmd.rd) begin
            r_rd_kind <= mem_kind[i_idx];
            r_rd_key  <= mem_key[i_idx];
            r_rd_prog <= mem_prog[i_idx];
            r_rd_fail <= mem_fail[i_idx];
            r_rd_exp  <= mem_exp[i_idx];
        end
        if (i_cmd.wr_hit || i_cmd.wr_fill) begin
            mem_kind[wa] <= r_kind;
            mem_key[wa]  <= r_key;
            mem_prog[wa] <= r_prog;
            mem_fail[wa] <= r_now;
            mem_exp[wa]  <= r_exp;
        end
        if (i_cmd.push) begin
            r_pd_kind <= r_rd_kind;
            r_pd_key  <= r_rd_key;
            r_pd_prog <= r_rd_prog;
            r_pd_fail <= r_rd_fail;
            r_pd_exp  <= r_rd_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_fp         <= '0;
            r_rd_valid   <= 1'b0;
        end else begin
            if (i_cmd.rd) r_rd_valid <= r_slot_valid[i_idx];
            if (i_cmd.wr_hit || i_cmd.wr_fill) r_slot_valid[wa] <= 1'b1;
            if (i_cmd.clr) r_slot_valid[i_idx] <= 1'b0;
            if (i_cmd.wr_fill) begin
                if (r_fp == IW'(TABLE_ENTRIES - 1)) r_fp <= '0;
                else r_fp <= r_fp + 1'b1;
            end
        end
    end

    // one live entry is held back so that the final word can carry last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have         <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.emit_chk || i_cmd.fin || (i_cmd.push && r_have);
            if (i_cmd.push) r_have <= 1'b1;
            else if (i_cmd.fin || i_cmd.ld) r_have <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_chk) begin
            o_is_held          <= o_stat.hit && o_stat.held;
            o_entry_valid      <= 1'b0;
            o_entry_kind       <= '0;
            o_entry_key        <= '0;
            o_entry_progress   <= '0;
            o_entry_failed_at  <= '0;
            o_entry_expires_at <= '0;
            o_last             <= 1'b1;
        end else if ((i_cmd.push || i_cmd.fin) && r_have) begin
            o_is_held          <= 1'b0;
            o_entry_valid      <= 1'b1;
            o_entry_kind       <= r_pd_kind;
            o_entry_key        <= r_pd_key;
            o_entry_progress   <= r_pd_prog;
            o_entry_failed_at  <= r_pd_fail;
            o_entry_expires_at <= r_pd_exp;
            o_last             <= i_cmd.fin;
        end else if (i_cmd.fin) begin
            o_is_held          <= 1'b0;
            o_entry_valid      <= 1'b0;
            o_entry_kind       <= '0;
            o_entry_key        <= '0;
            o_entry_progress   <= '0;
            o_entry_failed_at  <= '0;
            o_entry_expires_at <= '0;
            o_last             <= 1'b1;
        end
    end

endmodule

FILE: rtl/eqt_checker.sv
`include "expiring_quarantine_table_assert.svh"

module eqt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_command,
    input logic       o_result_valid,
    input logic       o_is_held,
    input logic       o_entry_valid,
    input logic       o_last
);
    import eqt_pkg::*;

    // a held answer is only ever the single final word of a check
    `EQT_ASSERT_NOW(a_held, i_clk, i_rst_n, o_result_valid && o_is_held, o_last && !o_entry_valid)
    // an accepted check always starts a scan
    `EQT_ASSERT_NEXT(a_check_busy, i_clk, i_rst_n, start && !busy && (i_command == CMD_CHECK), busy)
    // nothing follows the final word of an item
    `EQT_ASSERT_NEXT(a_quiet_after_last, i_clk, i_rst_n, o_result_valid && o_last, !o_result_valid)

endmodule

bind expiring_quarantine_table eqt_checker u_eqt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_command     (i_command),
    .o_result_valid(o_result_valid),
    .o_is_held     (o_is_held),
    .o_entry_valid (o_entry_valid),
    .o_last        (o_last)
);

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import eqt_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         SLOTS      = 16;
    localparam int         CYCLE_CAP  = 400000;
    localparam int         SETTLE     = 2 * SLOTS + 8;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  kind;
        logic [63:0] key;
        logic [63:0] prog;
        logic [63:0] now;
    } cmd_word_t;

    typedef struct packed {
        logic        held;
        logic        ev;
        logic [3:0]  kind;
        logic [63:0] key;
        logic [63:0] prog;
        logic [63:0] failed_at;
        logic [63:0] expires_at;
        logic        last;
    } table_word_t;

    // directed row: typed marks an answer read straight off the spec
    typedef struct packed {
        cmd_word_t w;
        logic      typed;
        logic      typed_held;
        logic      typed_ev;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [1:0] i_command;
    logic [3:0] i_kind;
    logic [63:0] i_key, i_progress, i_now_ms;
    logic o_result_valid, o_is_held, o_entry_valid, o_last;
    logic [3:0] o_entry_kind;
    logic [63:0] o_entry_key, o_entry_progress, o_entry_failed_at, o_entry_expires_at;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;

    expiring_quarantine_table uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_kind(i_kind), .i_key(i_key),
        .i_progress(i_progress), .i_now_ms(i_now_ms),
        .o_result_valid(o_result_valid), .o_is_held(o_is_held),
        .o_entry_valid(o_entry_valid), .o_entry_kind(o_entry_kind),
        .o_entry_key(o_entry_key), .o_entry_progress(o_entry_progress),
        .o_entry_failed_at(o_entry_failed_at), .o_entry_expires_at(o_entry_expires_at),
        .o_last(o_last), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    // shadow copy of the table
    logic [3:0]  tbl_kind [SLOTS];
    logic [63:0] tbl_key [SLOTS];
    logic [63:0] tbl_prog [SLOTS];
    logic [63:0] tbl_failed [SLOTS];
    logic [63:0] tbl_expiry [SLOTS];
    int unsigned fill_ptr;
    logic [31:0] hold_ms;

    table_word_t awaited_words[$];
    int errors = 0;
    int cycles = 0;
    int idle_pct = 0;
    logic [63:0] clock_ms = 64'd1000;
    logic [63:0] key_pool [6];
    logic [63:0] prog_pool [3];

    function automatic int find_entry(logic [3:0] k, logic [63:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_kind[i] == k && tbl_key[i] == key) return i;
        return -1;
    endfunction

    function automatic void clear_entry(int i);
        tbl_kind[i] = '0;
        tbl_key[i] = '0;
        tbl_prog[i] = '0;
        tbl_failed[i] = '0;
        tbl_expiry[i] = '0;
    endfunction

    function automatic void table_reset();
        for (int i = 0; i < SLOTS; i++) clear_entry(i);
        fill_ptr = 0;
        hold_ms = HOLD_RESET;
    endfunction

    function automatic void apply_word(cmd_word_t w, output table_word_t res[$]);
        table_word_t r;
        int s;
        res = {};
        case (w.cmd)
            CMD_INSERT: begin
                if (w.kind != 4'd0) begin
                    s = find_entry(w.kind, w.key);
                    if (s < 0) begin
                        s = fill_ptr;
                        fill_ptr = (fill_ptr + 1) % SLOTS;
                    end
                    tbl_kind[s] = w.kind;
                    tbl_key[s] = w.key;
                    tbl_prog[s] = w.prog;
                    tbl_failed[s] = w.now;
                    tbl_expiry[s] = w.now + {32'd0, hold_ms};
                end
            end
            CMD_CHECK: begin
                r = '0;
                r.last = 1'b1;
                if (w.kind != 4'd0) begin
                    s = find_entry(w.kind, w.key);
                    if (s >= 0) begin
                        if (w.now >= tbl_expiry[s] || w.prog != tbl_prog[s]) clear_entry(s);
                        else r.held = 1'b1;
                    end
                end
                res.push_back(r);
            end
            CMD_SNAPSHOT: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_kind[i] != 4'd0 && w.now < tbl_expiry[i]) begin
                        r = '0;
                        r.ev = 1'b1;
                        r.kind = tbl_kind[i];
                        r.key = tbl_key[i];
                        r.prog = tbl_prog[i];
                        r.failed_at = tbl_failed[i];
                        r.expires_at = tbl_expiry[i];
                        res.push_back(r);
                    end
                end
                if (res.size() == 0) begin
                    r = '0;
                    res.push_back(r);
                end
                res[res.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // drive one word and hold it until taken; start stays high when no gap follows
    task automatic send_word(cmd_word_t w, logic typed, logic t_held, logic t_ev);
        table_word_t res[$];
        table_word_t t;
        start <= 1'b1;
        i_command <= w.cmd;
        i_kind <= w.kind;
        i_key <= w.key;
        i_progress <= w.prog;
        i_now_ms <= w.now;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        apply_word(w, res);
        if (typed) begin
            t = '0;
            t.held = t_held;
            t.ev = t_ev;
            t.last = 1'b1;
            awaited_words.push_back(t);
        end else begin
            foreach (res[i]) awaited_words.push_back(res[i]);
        end
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (awaited_words.size() != 0 || busy) @(posedge i_clk);
        // an insert gives no word, so let the scan finish
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_hold(logic [31:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {REG_HOLD, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        hold_ms = v;
        @(posedge i_clk);
    endtask

    function automatic cmd_word_t random_word();
        cmd_word_t w;
        int c;
        c = $urandom_range(99);
        if (c < 45) w.cmd = CMD_INSERT;
        else if (c < 80) w.cmd = CMD_CHECK;
        else if (c < 95) w.cmd = CMD_SNAPSHOT;
        else w.cmd = CMD_UNUSED;
        w.kind = ($urandom_range(99) < 80) ? 4'($urandom_range(1, 3)) : 4'($urandom_range(15));
        w.key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(5)]
                                          : {$urandom, $urandom};
        w.prog = ($urandom_range(99) < 85) ? prog_pool[$urandom_range(2)]
                                           : {$urandom, $urandom};
        clock_ms = clock_ms + 64'($urandom_range(0, 400));
        w.now = ($urandom_range(99) < 4) ? {$urandom, $urandom} : clock_ms;
        return w;
    endfunction

    always @(posedge i_clk) begin
        table_word_t e;
        if (i_rst_n && o_result_valid) begin
            if (awaited_words.size() == 0) begin
                $error("result word with nothing awaited");
                errors++;
            end else begin
                e = awaited_words.pop_front();
                if (o_is_held !== e.held) begin
                    $error("is_held: expected %0h, got %0h", e.held, o_is_held);
                    errors++;
                end
                if (o_entry_valid !== e.ev) begin
                    $error("entry_valid: expected %0h, got %0h", e.ev, o_entry_valid);
                    errors++;
                end
                if (o_entry_kind !== e.kind) begin
                    $error("entry_kind: expected %0h, got %0h", e.kind, o_entry_kind);
                    errors++;
                end
                if (o_entry_key !== e.key) begin
                    $error("entry_key: expected %0h, got %0h", e.key, o_entry_key);
                    errors++;
                end
                if (o_entry_progress !== e.prog) begin
                    $error("entry_progress: expected %0h, got %0h", e.prog, o_entry_progress);
                    errors++;
                end
                if (o_entry_failed_at !== e.failed_at) begin
                    $error("entry_failed_at: expected %0h, got %0h",
                           e.failed_at, o_entry_failed_at);
                    errors++;
                end
                if (o_entry_expires_at !== e.expires_at) begin
                    $error("entry_expires_at: expected %0h, got %0h",
                           e.expires_at, o_entry_expires_at);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0h, got %0h", e.last, o_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    row_t rows [] = '{
        '{'{CMD_SNAPSHOT, 4'd0, 64'd0, 64'd0, 64'd0}, 1'b1, 1'b0, 1'b0},
        '{'{CMD_CHECK, 4'd5, 64'd1, 64'd0, 64'd0}, 1'b1, 1'b0, 1'b0},
        '{'{CMD_INSERT, 4'd0, 64'd7, 64'd3, 64'd10}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_CHECK, 4'd0, 64'd7, 64'd3, 64'd11}, 1'b1, 1'b0, 1'b0},
        '{'{CMD_INSERT, 4'd15, '1, '1, 64'd100}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_INSERT, 4'd1, 64'd0, 64'd0, 64'd0}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_CHECK, 4'd15, '1, '1, 64'd200}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_SNAPSHOT, 4'd0, 64'd0, 64'd0, 64'd300}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_UNUSED, 4'd15, '1, '1, '1}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_CHECK, 4'd1, 64'd0, 64'd5, 64'd10}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_SNAPSHOT, 4'd0, 64'd0, 64'd0, 64'd20}, 1'b0, 1'b0, 1'b0},
        // expiry wraps past the top of the range
        '{'{CMD_INSERT, 4'd2, 64'd9, 64'd4, 64'hFFFF_FFFF_FFFF_FFF0}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_SNAPSHOT, 4'd0, 64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFF1}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_CHECK, 4'd2, 64'd9, 64'd4, 64'hFFFF_FFFF_FFFF_FFF1}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_INSERT, 4'd15, '1, '1, 64'd100}, 1'b0, 1'b0, 1'b0},
        // exactly at the expiry the entry is gone
        '{'{CMD_CHECK, 4'd15, '1, '1, 64'd60100}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_INSERT, 4'd3, 64'd4, 64'd1, 64'd500}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_INSERT, 4'd3, 64'd4, 64'd2, 64'd600}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_INSERT, 4'd4, 64'd4, 64'd2, 64'd600}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_SNAPSHOT, 4'd0, 64'd0, 64'd0, 64'd700}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_CHECK, 4'd3, 64'd4, 64'd2, 64'd700}, 1'b0, 1'b0, 1'b0}
    };

    logic [31:0] phase_hold [3];
    int phase_idle [3] = '{13, 72, 0};

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_command <= CMD_INSERT;
        i_kind <= '0;
        i_key <= '0;
        i_progress <= '0;
        i_now_ms <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        table_reset();
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        foreach (prog_pool[i]) prog_pool[i] = {$urandom, $urandom};
        phase_hold[0] = 32'hFFFF_FFFF;
        phase_hold[1] = $urandom_range(50, 3000);
        phase_hold[2] = $urandom;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].typed_held, rows[i].typed_ev);
        drain();

        // a zero hold makes every entry expire at once
        write_hold(32'd0);
        for (int i = 0; i < 8; i++) send_word(random_word(), 1'b0, 1'b0, 1'b0);
        drain();

        for (int p = 0; p < 3; p++) begin
            write_hold(phase_hold[p]);
            idle_pct = phase_idle[p];
            for (int i = 0; i < 70; i++) begin
                send_word(random_word(), 1'b0, 1'b0, 1'b0);
                if (p == 0 && i == 35) begin
                    start <= 1'b0;
                    @(posedge i_clk);
                    while (awaited_words.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (errors == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end
endmodule
